/* design/segment_lcd_serial_writer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the segment LCD serial writer
// Shared property wrappers, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_LCD_SERIAL_WRITER_UNIT_ASSERT_SVH
`define SEGMENT_LCD_SERIAL_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SLSW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slsw same-cycle check failed");

// Next-cycle implication.
`define SLSW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slsw next-cycle check failed");

`endif

/* design/slsw_pkg.sv */
// ----------------------------------------------------------------------------
// slsw_pkg
// Types, codes and the seven-segment font for the segment LCD serial writer.
// ----------------------------------------------------------------------------
`default_nettype none

package slsw_pkg;

  localparam int FONT_ENTRIES    = 95;
  localparam int POSITION_COUNT  = 30;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Longest run: two 13-bit write frames.
  localparam int FRAME_BITS = 13;
  localparam int RUN_BITS   = 2 * FRAME_BITS;
  localparam int LEN_W      = $clog2(RUN_BITS + 1);

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_NIB  = 2'd2;

  localparam logic [2:0] MODE_CMD   = 3'b100;
  localparam logic [2:0] MODE_WRITE = 3'b101;

  localparam logic [7:0] CHAR_LOW  = 8'd32;
  localparam logic [7:0] CHAR_HIGH = 8'd126;

  // Bit index that closes the first frame of a character run.
  localparam logic [LEN_W-1:0] MID_INDEX = LEN_W'(FRAME_BITS - 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [4:0] position;
    logic [7:0] command_byte;
    logic [5:0] ram_address;
    logic [3:0] nibble;
    logic       first;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic serial_bit;
    logic select_release;
    logic run_end;
  } out_item_t;

  // One classified item: bits left-aligned, sent from the top bit down.
  typedef struct packed {
    logic [RUN_BITS-1:0] bits;
    logic [LEN_W-1:0]    len;
    logic                mid_release;
    logic                end_release;
  } run_desc_t;

  localparam logic [7:0] FONT_ROM [FONT_ENTRIES] = '{
    8'h00, 8'hD0, 8'h12, 8'h7E, 8'h6B, 8'h00, 8'h00, 8'h10, 8'h06, 8'h50,
    8'h33, 8'h00, 8'h40, 8'h20, 8'h80, 8'h34, 8'h5F, 8'h50, 8'h3D, 8'h79,
    8'h72, 8'h6B, 8'h6F, 8'h53, 8'h7F, 8'h7B, 8'h00, 8'h00, 8'h00, 8'h28,
    8'h00, 8'h35, 8'h7D, 8'h77, 8'h7F, 8'h0F, 8'h5F, 8'h2F, 8'h27, 8'h4F,
    8'h76, 8'h50, 8'h5D, 8'h2B, 8'h0E, 8'h45, 8'h57, 8'h5F, 8'h37, 8'h73,
    8'h07, 8'h6B, 8'h2E, 8'h5E, 8'h1A, 8'h4D, 8'h76, 8'h7A, 8'h3D, 8'h0F,
    8'h62, 8'h59, 8'h00, 8'h08, 8'h02, 8'h7D, 8'h6E, 8'h2C, 8'h7C, 8'h3F,
    8'h07, 8'h7B, 8'h66, 8'h40, 8'h58, 8'h67, 8'h06, 8'h65, 8'h64, 8'h6C,
    8'h37, 8'h73, 8'h24, 8'h6B, 8'h2E, 8'h4C, 8'h1A, 8'h4D, 8'h76, 8'h7A,
    8'h71, 8'h70, 8'h50, 8'h26, 8'h01
  };

  // Blank for anything outside the printable range.
  function automatic logic [7:0] glyph_of(input logic [7:0] code);
    logic [7:0] idx;
    idx = code - CHAR_LOW;
    if (code >= CHAR_LOW && code <= CHAR_HIGH) begin
      return FONT_ROM[idx[6:0]];
    end
    return 8'h00;
  endfunction

endpackage

`default_nettype wire

/* design/slsw_front.sv */
// ----------------------------------------------------------------------------
// slsw_front
// Accepts items, looks up the font and builds one serial run descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module slsw_front import slsw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  in_item,
  output logic           desc_valid,
  output run_desc_t      desc,
  input  wire logic      desc_full
);

  logic      valid_r, valid_nxt;
  run_desc_t desc_r, desc_nxt;
  logic      accept;
  logic      known;
  logic [7:0] glyph;
  logic [5:0] addr_lo;
  logic [5:0] addr_hi;

  assign full       = valid_r && desc_full;
  assign accept     = push && !full;
  assign desc_valid = valid_r;
  assign desc       = desc_r;

  assign glyph   = glyph_of(in_item.char_code);
  // position*2+4, wrapped to six bits; the pair's second address is odd.
  assign addr_lo = {in_item.position, 1'b0} + 6'd4;
  assign addr_hi = {addr_lo[5:1], 1'b1};

  always_comb begin
    known             = 1'b1;
    desc_nxt.bits     = '0;
    desc_nxt.len      = '0;
    desc_nxt.mid_release = 1'b0;
    desc_nxt.end_release = in_item.last;
    case (in_item.kind)
      KIND_CHAR: begin
        desc_nxt.bits = {MODE_WRITE, addr_lo, glyph[3:0], MODE_WRITE, addr_hi, glyph[7:4]};
        desc_nxt.len  = LEN_W'(RUN_BITS);
        desc_nxt.mid_release = 1'b1;
        desc_nxt.end_release = 1'b1;
      end
      KIND_CMD: begin
        if (in_item.first) begin
          desc_nxt.bits = {MODE_CMD, in_item.command_byte, 1'b0, (RUN_BITS - 12)'(0)};
          desc_nxt.len  = LEN_W'(12);
        end else begin
          desc_nxt.bits = {in_item.command_byte, 1'b0, (RUN_BITS - 9)'(0)};
          desc_nxt.len  = LEN_W'(9);
        end
      end
      KIND_NIB: begin
        if (in_item.first) begin
          desc_nxt.bits = {MODE_WRITE, in_item.ram_address, in_item.nibble,
                           (RUN_BITS - 13)'(0)};
          desc_nxt.len  = LEN_W'(13);
        end else begin
          desc_nxt.bits = {in_item.nibble, (RUN_BITS - 4)'(0)};
          desc_nxt.len  = LEN_W'(4);
        end
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Drop unknown kinds at the door; hold a built run until the queue takes it.
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = known;
    end else if (valid_r && !desc_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/slsw_queue.sv */
// ----------------------------------------------------------------------------
// slsw_queue
// Short descriptor queue between the front and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module slsw_queue import slsw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  wire run_desc_t wr_desc,
  output logic           q_full,
  output logic           rd_valid,
  input  wire logic      rd_en,
  output run_desc_t      rd_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_desc_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign q_full   = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_desc  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

`default_nettype wire

/* design/slsw_back.sv */
// ----------------------------------------------------------------------------
// slsw_back
// Shifts one run out a bit per cycle into the result register, while that register is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module slsw_back import slsw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      run_valid,
  input  wire run_desc_t run_desc,
  output logic           run_take,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      out_item
);

  logic                busy_r, busy_nxt;
  logic [RUN_BITS-1:0] sh_r;
  logic [LEN_W-1:0]    left_r;
  logic [LEN_W-1:0]    cnt_r;
  logic                mid_r, end_rel_r;
  logic                ovalid_r, ovalid_nxt;
  out_item_t           oitem_r;
  logic                adv, last_bit, rel_bit;

  assign empty    = !ovalid_r;
  assign out_item = oitem_r;

  assign adv      = busy_r && (!ovalid_r || pop);
  assign last_bit = (left_r == LEN_W'(1));
  assign rel_bit  = (last_bit && end_rel_r) || (mid_r && cnt_r == MID_INDEX);
  // Load the next run on the cycle the current one sends its last bit.
  assign run_take = run_valid && (!busy_r || (adv && last_bit));

  always_comb begin
    busy_nxt = busy_r;
    if (run_take) begin
      busy_nxt = 1'b1;
    end else if (adv && last_bit) begin
      busy_nxt = 1'b0;
    end
    ovalid_nxt = ovalid_r;
    if (adv) begin
      ovalid_nxt = 1'b1;
    end else if (pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      left_r   <= '0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      if (run_take) begin
        left_r <= run_desc.len;
      end else if (adv) begin
        left_r <= left_r - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_take) begin
      sh_r      <= run_desc.bits;
      cnt_r     <= '0;
      mid_r     <= run_desc.mid_release;
      end_rel_r <= run_desc.end_release;
    end else if (adv) begin
      sh_r  <= {sh_r[RUN_BITS-2:0], 1'b0};
      cnt_r <= cnt_r + LEN_W'(1);
    end
    if (adv) begin
      oitem_r.serial_bit     <= sh_r[RUN_BITS-1];
      oitem_r.select_release <= rel_bit;
      oitem_r.run_end        <= last_bit;
    end
  end

`include "segment_lcd_serial_writer_unit_assert.svh"

  `SLSW_ASSERT_NOW(a_busy_has_bits, busy_r, left_r != '0 && left_r <= LEN_W'(RUN_BITS))
  `SLSW_ASSERT_NOW(a_mid_release_place, adv && rel_bit && !last_bit, mid_r && cnt_r == MID_INDEX)
  `SLSW_ASSERT_NEXT(a_load_starts_run, run_take, busy_r && cnt_r == '0)
  `SLSW_ASSERT_NEXT(a_run_drains, adv && last_bit && !run_take, !busy_r)

endmodule

`default_nettype wire

/* design/segment_lcd_serial_writer_unit.sv */
// ----------------------------------------------------------------------------
// segment_lcd_serial_writer_unit
// Serializer for a three-wire segment LCD link: items in, one bit per result.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           beat
//   input     in         push / full         in_item  (in_item_t)
//   result    out        empty / pop         out_item (out_item_t), one serial bit
//
// Runs: a run leaves at one bit per cycle while the result is not held: 26
//   bits for a character, 9 or 12 for a command, 4 or 13 for a nibble
//   write. The back end shifts them out through a single-bit shifter.
// Runs follow each other with no gap bit: the next descriptor loads on the
//   cycle the current run sends its last bit.
// Reset: synchronous, rst_n low; clears the front stage, the queue and the
//   shifter. No clearing pass.
// Stalls: a held result stops the shifter only; the front keeps accepting
//   until the descriptor queue and the front stage are both full.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_lcd_serial_writer_unit import slsw_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_item
);

  // Front to queue: one classified run per beat.
  logic      f_valid;
  run_desc_t f_desc;
  logic      q_full;

  // Queue to serializer.
  logic      q_valid;
  run_desc_t q_desc;
  logic      q_take;

  // Classify the item, look up the font, build the bit run.
  slsw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .desc_valid (f_valid),
    .desc       (f_desc),
    .desc_full  (q_full)
  );

  // Hold runs so a stalled result side does not block input.
  slsw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (f_valid),
    .wr_desc  (f_desc),
    .q_full   (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_take),
    .rd_desc  (q_desc)
  );

  // Shift each run out a bit at a time, marking chip-select release and run end.
  slsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_valid (q_valid),
    .run_desc  (q_desc),
    .run_take  (q_take),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
